FILE: sv/cpra_pkg.sv
// Package for the contiguous page run allocator: field widths, word types,
// walker control struct. No dependencies.
package cpra_pkg;

   localparam int PAGE_SHIFT    = 12;
   localparam int PAGE_BYTES    = 4096;
   localparam int NUM_PAGES_DEF = 1024;

   localparam int START_W = 22;
   localparam int END_W   = 23;
   localparam int SIZE_W  = 23;
   localparam int ADDR_W  = 22;

   // page-number widths that follow from the field widths
   localparam int LO_W   = START_W - PAGE_SHIFT;     // start page
   localparam int HI_W   = END_W - PAGE_SHIFT;       // end page
   localparam int NEED_W = SIZE_W - PAGE_SHIFT + 1;  // rounded-up page count

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [START_W-1:0] start_addr;
      logic [END_W-1:0]   end_addr;
      logic [SIZE_W-1:0]  size_bytes;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] run_addr;
   } rsp_type;

   // walker control: load a new [first, stop) range, or advance one page
   typedef struct packed {
      logic load;
      logic step;
   } walk_ctl_type;

endpackage

FILE: sv/cpra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpra_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/cpra_walk.sv
// Shared page walker: one pointer, one incrementer, one end compare.
// Serves the clear sweep, the scan, the mark pass and the free pass. Uses cpra_pkg.
module cpra_walk #(
   parameter int IW        = 13,
   parameter int NUM_PAGES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cpra_pkg::walk_ctl_type ctl,
   input  logic [IW-1:0]         first,
   input  logic [IW-1:0]         stop,
   output logic [IW-1:0]         ptr,
   output logic                  act
);
   import cpra_pkg::*;

   logic [IW-1:0] ptr_ff, ptr_in;
   logic [IW-1:0] stop_ff, stop_in;
   logic          act_ff, act_in;
   logic [IW-1:0] ptr_inc;

   assign ptr_inc = ptr_ff + IW'(1);

   always_comb begin
      ptr_in  = ptr_ff;
      stop_in = stop_ff;
      act_in  = act_ff;
      priority if (ctl.load) begin
         ptr_in  = first;
         stop_in = stop;
         act_in  = (first < stop);
      end else if (ctl.step && act_ff) begin
         ptr_in = ptr_inc;
         act_in = (ptr_inc != stop_ff);
      end
   end

   // reset arms a full sweep over the map
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         stop_ff <= IW'(NUM_PAGES);
         act_ff  <= 1'b1;
      end else begin
         ptr_ff  <= ptr_in;
         stop_ff <= stop_in;
         act_ff  <= act_in;
      end
   end

   assign ptr = ptr_ff;
   assign act = act_ff;

endmodule

FILE: sv/contiguous_page_run_allocator.sv
// Top level of the first-fit contiguous page run allocator: sequencer, page map RAM,
// shared page walker. Uses cpra_pkg, cpra_ram, cpra_walk.
//
//   channel | ports                        | direction | handshake
//   --------+------------------------------+-----------+------------------------------
//   request | start, busy, req_data        | in        | word taken when start & !busy
//   result  | rsp_strobe, rsp_data         | out       | one-cycle strobe, no stall
//
// Sequence: an allocate scans the pages of its window, then marks the pages granted
// in a mark pass; a free releases its pages; a zero-size allocate answers without a
// scan. The single page walker and the one RAM port per direction handle one page a
// cycle.
// Reset: the map clears itself in a sweep over all pages; busy is high meanwhile.
// The result strobe lasts one cycle and the receiver cannot stall it.
module contiguous_page_run_allocator #(
   parameter int NUM_PAGES = cpra_pkg::NUM_PAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cpra_pkg::req_type req_data,
   output logic              rsp_strobe,
   output cpra_pkg::rsp_type rsp_data
);
   import cpra_pkg::*;

   localparam int PIDX_W = $clog2(NUM_PAGES);
   localparam int CNT_W  = $clog2(NUM_PAGES + 1);
   // wide enough for a page count, the map size and start + need
   localparam int IW     = ((CNT_W > NEED_W) ? CNT_W : NEED_W) + 1;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_LOAD  = 6'b000100,
      S_SCAN  = 6'b001000,
      S_MARK  = 6'b010000,
      S_FREE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic              cmd_ff, cmd_in;
   logic [LO_W-1:0]   lo_ff, lo_in;
   logic [HI_W-1:0]   hi_ff, hi_in;
   logic [NEED_W-1:0] need_ff, need_in;

   // scan bookkeeping
   logic [IW-1:0] run_ff, run_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_vld_ff, rd_vld_in;

   // result register
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;

   // walker
   walk_ctl_type  wctl;
   logic [IW-1:0] w_first, w_stop, w_ptr;
   logic          w_act;

   // RAM
   logic              ram_we, ram_wdata, ram_re, ram_rdata;
   logic [PIDX_W-1:0] ram_addr;

   logic              accept;
   logic [IW-1:0]     np, lo_ext, hi_ext, need_ext, sum;
   logic [IW-1:0]     free_stop, scan_stop, run_next, head_sel;
   logic              hit;
   logic [IW+PAGE_SHIFT-1:0] addr_wide;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   assign np       = IW'(NUM_PAGES);
   assign lo_ext   = IW'(lo_ff);
   assign hi_ext   = IW'(hi_ff);
   assign need_ext = IW'(need_ff);
   assign sum      = lo_ext + need_ext;
   // free range end and scan window end, both clamped to the map
   assign free_stop = (sum < np) ? sum : np;
   assign scan_stop = (hi_ext < np) ? hi_ext : np;

   // scan check on the page read in the previous cycle
   assign run_next = run_ff + IW'(1);
   assign head_sel = (run_ff == '0) ? rd_idx_ff : head_ff;
   assign hit      = (state_ff == S_SCAN) && rd_vld_ff && !ram_rdata &&
                     (run_next >= need_ext);
   assign addr_wide = {head_sel, {PAGE_SHIFT{1'b0}}};

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      need_in    = need_ff;
      run_in     = run_ff;
      head_in    = head_ff;
      rd_idx_in  = w_ptr;
      rd_vld_in  = 1'b0;
      rsp_vld_in = 1'b0;
      rsp_in     = rsp_ff;
      wctl       = '0;
      w_first    = lo_ext;
      w_stop     = scan_stop;
      ram_we     = 1'b0;
      ram_wdata  = 1'b0;
      ram_re     = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = w_act;
            wctl.step = 1'b1;
            if (!w_act) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_data.cmd;
               lo_in    = req_data.start_addr[START_W-1:PAGE_SHIFT];
               hi_in    = req_data.end_addr[END_W-1:PAGE_SHIFT];
               // round size up to whole pages
               need_in  = {1'b0, req_data.size_bytes[SIZE_W-1:PAGE_SHIFT]}
                        + NEED_W'(|req_data.size_bytes[PAGE_SHIFT-1:0]);
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            priority if (cmd_ff == CMD_FREE) begin
               wctl.load = 1'b1;
               w_stop    = free_stop;
               state_in  = S_FREE;
            end else if (need_ff == '0) begin
               rsp_vld_in = 1'b1;
               rsp_in     = '0;
               state_in   = S_IDLE;
            end else begin
               wctl.load = 1'b1;
               run_in    = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (hit) begin
               // run complete: walk back over it and mark used
               wctl.load       = 1'b1;
               w_first         = head_sel;
               w_stop          = rd_idx_ff + IW'(1);
               head_in         = head_sel;
               rsp_in.found    = 1'b1;
               rsp_in.run_addr = addr_wide[ADDR_W-1:0];
               state_in        = S_MARK;
            end else if (!rd_vld_ff && !w_act) begin
               rsp_vld_in = 1'b1;
               rsp_in     = '0;
               state_in   = S_IDLE;
            end else begin
               ram_re    = w_act;
               rd_vld_in = w_act;
               wctl.step = 1'b1;
               if (rd_vld_ff) begin
                  if (!ram_rdata) begin
                     run_in  = run_next;
                     head_in = head_sel;
                  end else begin
                     run_in = '0;
                  end
               end
            end
         end
         S_MARK: begin
            ram_we    = w_act;
            ram_wdata = 1'b1;
            wctl.step = 1'b1;
            if (!w_act) begin
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_FREE: begin
            ram_we    = w_act;
            wctl.step = 1'b1;
            if (!w_act) begin
               rsp_vld_in      = 1'b1;
               rsp_in.found    = 1'b1;
               rsp_in.run_addr = '0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      need_ff   <= need_in;
      run_ff    <= run_in;
      head_ff   <= head_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
   end

   assign ram_addr = w_ptr[PIDX_W-1:0];

   cpra_walk #(
      .IW        (IW),
      .NUM_PAGES (NUM_PAGES)
   ) u_walk (
      .clock (clock),
      .reset (reset),
      .ctl   (wctl),
      .first (w_first),
      .stop  (w_stop),
      .ptr   (w_ptr),
      .act   (w_act)
   );

   cpra_ram #(
      .WIDTH (1),
      .DEPTH (NUM_PAGES)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   // a request is always followed by a busy period
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not raise busy");

   // strobe is a pulse and is never held high
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // finishing a request always produces exactly the strobe
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) != S_CLEAR) && $fell(busy) |-> rsp_strobe)
      else $error("request finished without a result");

   // a refused allocation reports no address
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.found |-> (rsp_data.run_addr == '0))
      else $error("not-found result carries an address");

   // the map is never read and written in the same cycle
   a_ram_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("page map read and written together");

endmodule
